### hw/rtl/fasta_record_parser_macros.svh
// Assertion macros shared by the FASTA record parser RTL.
`ifndef FASTA_RECORD_PARSER_MACROS_SVH
`define FASTA_RECORD_PARSER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define FRP_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define FRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/frp_pkg.sv
// Types, constants and base conversion for the FASTA record parser.
`default_nettype none

package frp_pkg;

  localparam int LEN_BITS   = 32;
  localparam int INDEX_BITS = 16;

  // Counter widths after clamping to the output field widths
  localparam int LEN_OUT_W   = 32;
  localparam int IDX_OUT_W   = 16;
  localparam int TOTAL_W     = 40;
  localparam int LEN_CNT_W   = (LEN_BITS < LEN_OUT_W) ? LEN_BITS : LEN_OUT_W;
  localparam int IDX_CNT_W   = (INDEX_BITS < IDX_OUT_W) ? INDEX_BITS : IDX_OUT_W;

  localparam int RES_DEPTH   = 4;
  localparam int RES_PTR_W   = $clog2(RES_DEPTH);
  localparam int RES_CNT_W   = $clog2(RES_DEPTH + 1);

  localparam logic [7:0] CH_GT  = 8'h3E;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] IUPAC_ALL = 8'd15;

  typedef enum logic [1:0] {
    MODE_IUPAC  = 2'd0,
    MODE_STRICT = 2'd1,
    MODE_RAW    = 2'd2,
    MODE_UPPER  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_BASE = 2'd0,
    KIND_HEAD = 2'd1,
    KIND_NAME = 2'd2,
    KIND_END  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                 item_kind;
    logic [7:0]            byte_value;
    logic [LEN_OUT_W-1:0]  length_value;
    logic [IDX_OUT_W-1:0]  record_number;
    logic [TOTAL_W-1:0]    total_bases;
    logic                  last_of_run;
  } res_t;

  // Results caused by one input beat, at most two
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } res_pair_t;

  function automatic logic [7:0] frp_convert(mode_t mode, logic [7:0] b);
    logic [7:0] up;
    logic [7:0] code;
    logic [7:0] strict;
    up = (b >= "a" && b <= "z") ? b - 8'd32 : b;
    code = 8'd0;
    strict = 8'd0;
    unique case (up)
      "A": begin code = 8'd1;  strict = "A"; end
      "B": begin code = 8'd14; strict = "N"; end
      "C": begin code = 8'd2;  strict = "C"; end
      "D": begin code = 8'd13; strict = "N"; end
      "G": begin code = 8'd4;  strict = "G"; end
      "H": begin code = 8'd11; strict = "N"; end
      "K": begin code = 8'd12; strict = "N"; end
      "M": begin code = 8'd3;  strict = "N"; end
      "N": begin code = IUPAC_ALL; strict = "N"; end
      "R": begin code = 8'd5;  strict = "N"; end
      "S": begin code = 8'd6;  strict = "N"; end
      "T": begin code = 8'd8;  strict = "T"; end
      "V": begin code = 8'd7;  strict = "N"; end
      "W": begin code = 8'd9;  strict = "N"; end
      "Y": begin code = 8'd10; strict = "N"; end
      default: begin code = 8'd0; strict = 8'd0; end
    endcase
    unique case (mode)
      MODE_IUPAC:  return code;
      MODE_STRICT: return strict;
      MODE_RAW:    return b;
      default:     return up;
    endcase
  endfunction

endpackage

`default_nettype wire

### hw/rtl/frp_in_if.sv
// Input byte channel of the FASTA record parser.
`default_nettype none

interface frp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_file;

  modport source (output valid, output in_byte, output end_of_file, input ready);
  modport sink   (input valid, input in_byte, input end_of_file, output ready);
endinterface

`default_nettype wire

### hw/rtl/frp_out_if.sv
// Result channel of the FASTA record parser.
`default_nettype none

interface frp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  item_kind;
  logic [7:0]  byte_value;
  logic [31:0] length_value;
  logic [15:0] record_number;
  logic [39:0] total_bases;
  logic        last_of_run;

  modport source (output valid, output item_kind, output byte_value, output length_value,
                  output record_number, output total_bases, output last_of_run,
                  input ready);
  modport sink   (input valid, input item_kind, input byte_value, input length_value,
                  input record_number, input total_bases, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/frp_step.sv
// Parse phase machine, header and sequence counters, and result formation.
`default_nettype none
`include "fasta_record_parser_macros.svh"

module frp_step (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_wdata,
  input  wire logic              acc,
  input  wire logic [7:0]        in_byte,
  input  wire logic              end_of_file,
  output frp_pkg::res_pair_t     pair
);
  import frp_pkg::*;

  typedef enum logic [2:0] {
    PH_SKIP = 3'b001,
    PH_HEAD = 3'b010,
    PH_SEQ  = 3'b100
  } phase_t;

  localparam logic [LEN_CNT_W-1:0] LEN_MAX   = {LEN_CNT_W{1'b1}};
  localparam logic [IDX_CNT_W-1:0] IDX_MAX   = {IDX_CNT_W{1'b1}};
  localparam logic [TOTAL_W-1:0]   TOTAL_MAX = {TOTAL_W{1'b1}};

  mode_t                mode_r;
  phase_t               phase_r, phase_nxt;
  logic [LEN_CNT_W-1:0] hcnt_r, hcnt_nxt;
  logic                 tab_seen_r, tab_seen_nxt;
  logic [LEN_CNT_W-1:0] tab_pos_r, tab_pos_nxt;
  logic                 sp_seen_r, sp_seen_nxt;
  logic [LEN_CNT_W-1:0] sp_pos_r, sp_pos_nxt;
  logic [LEN_CNT_W-1:0] seq_r, seq_nxt;
  logic [IDX_CNT_W-1:0] idx_r, idx_nxt;
  logic [TOTAL_W-1:0]   total_r, total_nxt;

  logic                 is_nl, is_gt, is_tab, is_sp;
  logic [LEN_CNT_W-1:0] hcnt_inc, seq_inc, close_len;
  logic [LEN_CNT_W-1:0] name_now, name_after, tab_pos_aft, sp_pos_aft;
  logic                 tab_seen_aft, sp_seen_aft;
  logic [IDX_CNT_W-1:0] idx_inc;
  logic [TOTAL_W:0]     total_sum;
  logic [TOTAL_W-1:0]   total_closed;
  res_pair_t            pair_c;

  function automatic res_t mk_res(kind_t k, logic [7:0] b, logic [LEN_CNT_W-1:0] len,
                                  logic [IDX_CNT_W-1:0] idx, logic [TOTAL_W-1:0] tot);
    res_t r;
    r.item_kind     = k;
    r.byte_value    = b;
    r.length_value  = LEN_OUT_W'(len);
    r.record_number = IDX_OUT_W'(idx);
    r.total_bases   = tot;
    r.last_of_run   = 1'b0;
    return r;
  endfunction

  assign is_nl  = (in_byte == CH_NL);
  assign is_gt  = (in_byte == CH_GT);
  assign is_tab = (in_byte == CH_TAB);
  assign is_sp  = (in_byte == CH_SP);

  assign hcnt_inc = (hcnt_r == LEN_MAX) ? hcnt_r : hcnt_r + 1'b1;
  assign seq_inc  = (seq_r == LEN_MAX) ? seq_r : seq_r + 1'b1;
  assign idx_inc  = (idx_r == IDX_MAX) ? idx_r : idx_r + 1'b1;

  assign name_now = tab_seen_r ? tab_pos_r : (sp_seen_r ? sp_pos_r : hcnt_r);

  // Name length when the cut-off header's last byte still counts
  assign tab_seen_aft = tab_seen_r | is_tab;
  assign tab_pos_aft  = tab_seen_r ? tab_pos_r : hcnt_r;
  assign sp_seen_aft  = sp_seen_r | is_sp;
  assign sp_pos_aft   = sp_seen_r ? sp_pos_r : hcnt_r;
  assign name_after   = tab_seen_aft ? tab_pos_aft : (sp_seen_aft ? sp_pos_aft : hcnt_inc);

  // Only sequence bytes close a record with a non-zero length
  assign close_len = (phase_r == PH_SEQ) ? ((is_gt || is_nl) ? seq_r : seq_inc)
                                         : '0;
  assign total_sum    = {1'b0, total_r} + (TOTAL_W + 1)'(close_len);
  assign total_closed = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];

  always_comb begin
    res_t  r_end;
    logic  closing;
    phase_nxt    = phase_r;
    hcnt_nxt     = hcnt_r;
    tab_seen_nxt = tab_seen_r;
    tab_pos_nxt  = tab_pos_r;
    sp_seen_nxt  = sp_seen_r;
    sp_pos_nxt   = sp_pos_r;
    seq_nxt      = seq_r;
    idx_nxt      = idx_r;
    total_nxt    = total_r;
    pair_c       = '0;
    closing      = 1'b0;
    r_end        = mk_res(KIND_END, 8'd0, close_len, idx_r, total_closed);

    unique case (phase_r)
      PH_SKIP: begin
        phase_nxt    = PH_HEAD;
        hcnt_nxt     = '0;
        tab_seen_nxt = 1'b0;
        tab_pos_nxt  = '0;
        sp_seen_nxt  = 1'b0;
        sp_pos_nxt   = '0;
        if (end_of_file) begin
          pair_c.n  = 2'd2;
          pair_c.r0 = mk_res(KIND_NAME, 8'd0, '0, idx_r, total_r);
          pair_c.r1 = r_end;
          closing   = 1'b1;
        end
      end
      PH_HEAD: begin
        if (is_nl) begin
          pair_c.r0 = mk_res(KIND_NAME, 8'd0, name_now, idx_r, total_r);
          phase_nxt = PH_SEQ;
          seq_nxt   = '0;
          if (end_of_file) begin
            pair_c.n  = 2'd2;
            pair_c.r1 = r_end;
            closing   = 1'b1;
          end else begin
            pair_c.n = 2'd1;
          end
        end else if (end_of_file) begin
          pair_c.n  = 2'd2;
          pair_c.r0 = mk_res(KIND_NAME, 8'd0, name_after, idx_r, total_r);
          pair_c.r1 = r_end;
          closing   = 1'b1;
        end else begin
          pair_c.n     = 2'd1;
          pair_c.r0    = mk_res(KIND_HEAD, in_byte, '0, idx_r, total_r);
          hcnt_nxt     = hcnt_inc;
          tab_seen_nxt = tab_seen_aft;
          tab_pos_nxt  = tab_pos_aft;
          sp_seen_nxt  = sp_seen_aft;
          sp_pos_nxt   = sp_pos_aft;
        end
      end
      PH_SEQ: begin
        if (is_gt) begin
          pair_c.n     = 2'd1;
          pair_c.r0    = r_end;
          closing      = 1'b1;
          phase_nxt    = PH_HEAD;
          hcnt_nxt     = '0;
          tab_seen_nxt = 1'b0;
          tab_pos_nxt  = '0;
          sp_seen_nxt  = 1'b0;
          sp_pos_nxt   = '0;
        end else if (is_nl) begin
          if (end_of_file) begin
            pair_c.n  = 2'd1;
            pair_c.r0 = r_end;
            closing   = 1'b1;
          end
        end else begin
          pair_c.r0 = mk_res(KIND_BASE, frp_convert(mode_r, in_byte), '0, idx_r, total_r);
          seq_nxt   = seq_inc;
          if (end_of_file) begin
            pair_c.n  = 2'd2;
            pair_c.r1 = r_end;
            closing   = 1'b1;
          end else begin
            pair_c.n = 2'd1;
          end
        end
      end
      default: begin
        phase_nxt = PH_SKIP;
      end
    endcase

    if (closing) begin
      total_nxt = total_closed;
      idx_nxt   = idx_inc;
    end

    if (pair_c.n == 2'd1) begin
      pair_c.r0.last_of_run = 1'b1;
    end
    if (pair_c.n == 2'd2) begin
      pair_c.r1.last_of_run = 1'b1;
    end

    // End of file returns the parser to its post-reset state
    if (end_of_file) begin
      phase_nxt    = PH_SKIP;
      hcnt_nxt     = '0;
      tab_seen_nxt = 1'b0;
      tab_pos_nxt  = '0;
      sp_seen_nxt  = 1'b0;
      sp_pos_nxt   = '0;
      seq_nxt      = '0;
      idx_nxt      = '0;
      total_nxt    = '0;
    end
  end

  always_comb begin
    pair = pair_c;
    if (!acc) begin
      pair.n = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_UPPER;
    end else if (cfg_we) begin
      mode_r <= mode_t'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_SKIP;
      hcnt_r     <= '0;
      tab_seen_r <= 1'b0;
      tab_pos_r  <= '0;
      sp_seen_r  <= 1'b0;
      sp_pos_r   <= '0;
      seq_r      <= '0;
      idx_r      <= '0;
      total_r    <= '0;
    end else if (acc) begin
      phase_r    <= phase_nxt;
      hcnt_r     <= hcnt_nxt;
      tab_seen_r <= tab_seen_nxt;
      tab_pos_r  <= tab_pos_nxt;
      sp_seen_r  <= sp_seen_nxt;
      sp_pos_r   <= sp_pos_nxt;
      seq_r      <= seq_nxt;
      idx_r      <= idx_nxt;
      total_r    <= total_nxt;
    end
  end

  `FRP_ASSERT_NEXT(a_eof_clears, acc && end_of_file,
    phase_r == PH_SKIP && total_r == '0 && idx_r == '0, "end of file did not clear state")
  `FRP_ASSERT_NEXT(a_total_grows, acc && !end_of_file,
    total_r >= $past(total_r), "running total went down within a file")
  `FRP_ASSERT(a_second_is_end, pair.n == 2'd2,
    pair.r1.item_kind == KIND_END && pair.r1.last_of_run, "second result not a record end")

endmodule

`default_nettype wire

### hw/rtl/frp_res_fifo.sv
// Result queue: takes up to two results a cycle while it has room, hands out one beat a cycle while pop is high.
`default_nettype none
`include "fasta_record_parser_macros.svh"

module frp_res_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire frp_pkg::res_pair_t pair,
  output logic                   room,
  input  wire logic              pop,
  output logic                   dout_valid,
  output frp_pkg::res_t          dout
);
  import frp_pkg::*;

  res_t                 mem_r [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt, wr_second;
  logic [RES_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 do_pop;

  // Room for a full pair keeps the input path free of the output ready
  assign room       = (cnt_r <= RES_CNT_W'(RES_DEPTH - 2));
  assign dout_valid = (cnt_r != '0);
  assign dout       = mem_r[rd_r];
  assign do_pop     = pop && dout_valid;
  assign wr_second  = wr_r + 1'b1;

  assign wr_nxt  = wr_r + RES_PTR_W'(pair.n);
  assign rd_nxt  = rd_r + RES_PTR_W'(do_pop);
  assign cnt_nxt = cnt_r + RES_CNT_W'(pair.n) - RES_CNT_W'(do_pop);

  always_ff @(posedge clk) begin
    if (pair.n != 2'd0) begin
      mem_r[wr_r] <= pair.r0;
    end
    if (pair.n == 2'd2) begin
      mem_r[wr_second] <= pair.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  `FRP_ASSERT(a_cnt_cap, 1'b1, cnt_r <= RES_CNT_W'(RES_DEPTH), "result queue overfilled")
  `FRP_ASSERT(a_push_room, pair.n != 2'd0, room, "results pushed without room")
  `FRP_ASSERT_NEXT(a_idle_hold, pair.n == 2'd0 && !do_pop,
    cnt_r == $past(cnt_r) && rd_r == $past(rd_r), "queue moved with no push or pop")

endmodule

`default_nettype wire

### hw/rtl/fasta_record_parser.sv
// Top level of the FASTA record parser.
//
//  channel  | dir | payload                                              | beat
//  in_chan  | in  | in_byte, end_of_file                                 | one file byte
//  out_chan | out | item_kind, byte_value, length_value, record_number,  | one result
//           |     | total_bases, last_of_run                             |
//  cfg      | in  | cfg_wdata = convert_mode                             | write on cfg_we
//
// A byte is taken while the result queue has room, and its results are in the queue in the next cycle.
// A byte gives zero, one or two results; the output moves one beat per cycle while
// out_chan.ready is high, so a byte that gives two results takes two beats at the output.
// in_chan.ready falls while the four-entry result queue holds more than two beats.
// Synchronous active-low reset; convert_mode resets to uppercase.
`default_nettype none

module fasta_record_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  frp_in_if.sink           in_chan,
  frp_out_if.source        out_chan,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_wdata
);
  import frp_pkg::*;

  res_pair_t pair;
  res_t      dout;
  logic      room;
  logic      acc;
  logic      dout_valid;

  assign in_chan.ready = room;
  assign acc           = in_chan.valid && room;

  frp_step u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .acc         (acc),
    .in_byte     (in_chan.in_byte),
    .end_of_file (in_chan.end_of_file),
    .pair        (pair)
  );

  frp_res_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .pair       (pair),
    .room       (room),
    .pop        (out_chan.ready),
    .dout_valid (dout_valid),
    .dout       (dout)
  );

  assign out_chan.valid         = dout_valid;
  assign out_chan.item_kind     = dout.item_kind;
  assign out_chan.byte_value    = dout.byte_value;
  assign out_chan.length_value  = dout.length_value;
  assign out_chan.record_number = dout.record_number;
  assign out_chan.total_bases   = dout.total_bases;
  assign out_chan.last_of_run   = dout.last_of_run;

endmodule

`default_nettype wire
